>>> hw/rtl/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and codes for the sorted-array max priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sapq_pkg;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 8;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // what every cell of the row does this cycle
    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,
        CMD_INS  = 2'd1,
        CMD_REM  = 2'd2
    } cell_cmd_t;

    typedef struct packed {
        opcode_t                  opcode;
        logic signed [KEY_W-1:0]  key_in;
    } req_beat_t;

    typedef struct packed {
        logic signed [KEY_W-1:0]  key_out;
        status_t                  status;
        logic [OCC_W-1:0]         occupancy;
    } rsp_beat_t;

    // broadcast to the whole cell row
    typedef struct packed {
        cell_cmd_t                cmd;
        logic signed [KEY_W-1:0]  key;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/sapq_cell.sv
// ----------------------------------------------------------------------------
// sapq_cell
// One slot of the descending key row: compare against the broadcast key and
// take own, new or neighbor key.
// ----------------------------------------------------------------------------
`default_nettype none

module sapq_cell (
    input  wire logic                                clk,
    input  wire sapq_pkg::cell_ctl_t                 ctl,
    input  wire logic                                occupied,
    input  wire logic signed [sapq_pkg::KEY_W-1:0]   prev_key,
    input  wire logic                                prev_gt,
    input  wire logic signed [sapq_pkg::KEY_W-1:0]   next_key,
    output logic                                     gt,
    output logic signed [sapq_pkg::KEY_W-1:0]        key
);

    logic signed [sapq_pkg::KEY_W-1:0] key_reg;
    logic signed [sapq_pkg::KEY_W-1:0] key_next;

    // held key strictly above the new one: it stays in place
    assign gt  = occupied && (key_reg > ctl.key);
    assign key = key_reg;

    always_comb
    begin
        key_next = key_reg;
        unique case (ctl.cmd)
            sapq_pkg::CMD_INS:
            begin
                if (!gt)
                begin
                    key_next = prev_gt ? ctl.key : prev_key;
                end
            end
            sapq_pkg::CMD_REM:
            begin
                key_next = next_key;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/sorted_array_max_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_array_max_priority_queue
// Max priority queue of signed 32-bit keys held in a row of sorted cells.
// ----------------------------------------------------------------------------
//
//  channel  | valid      | stall      | payload          | beat
//  ---------+------------+------------+------------------+---------------------
//  request  | req_valid  | req_stall  | req (req_beat_t) | enqueue or dequeue
//  response | rsp_valid  | rsp_stall  | rsp (rsp_beat_t) | one per request beat
//
//  One request beat per cycle while req_stall is low; its response appears the next
//  cycle. The whole cell row updates at once (one compare per cell), so the row
//  sets the rate.
//  Reset clears the key count and the response valid; cell contents are
//  left as they are and are only read below the count.
//  req_stall rises only while a response is held by rsp_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_max_priority_queue #(
    parameter int DEPTH = 128
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire sapq_pkg::req_beat_t  req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output sapq_pkg::rsp_beat_t       rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Cells are kept in descending order: cell 0 holds the largest key, so a
    // dequeue reads a fixed place and the row shifts down by one.
    logic signed [sapq_pkg::KEY_W-1:0] cell_key [DEPTH];
    logic                              cell_gt  [DEPTH];

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    sapq_pkg::rsp_beat_t  rsp_reg;
    sapq_pkg::rsp_beat_t  rsp_next;
    sapq_pkg::cell_ctl_t  ctl;

    logic accept;
    logic full;
    logic empty;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // decode the beat into a row command, count update and response
    always_comb
    begin
        ctl.cmd        = sapq_pkg::CMD_HOLD;
        ctl.key        = req.key_in;
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (accept)
        begin
            rsp_valid_next   = 1'b1;
            rsp_next.key_out = '0;
            rsp_next.status  = sapq_pkg::ST_OK;
            unique case (req.opcode)
                sapq_pkg::OP_ENQ:
                begin
                    if (full)
                    begin
                        rsp_next.status = sapq_pkg::ST_FULL;   // key dropped
                    end
                    else
                    begin
                        ctl.cmd    = sapq_pkg::CMD_INS;
                        count_next = count_reg + 1'b1;
                    end
                end
                sapq_pkg::OP_DEQ:
                begin
                    if (empty)
                    begin
                        rsp_next.status = sapq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctl.cmd          = sapq_pkg::CMD_REM;
                        rsp_next.key_out = cell_key[0];
                        count_next       = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    ctl.cmd = sapq_pkg::CMD_HOLD;
                end
            endcase
            rsp_next.occupancy = sapq_pkg::OCC_W'(count_next);
        end
    end

    // the cell row
    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        logic signed [sapq_pkg::KEY_W-1:0] prev_key;
        logic                              prev_gt;
        logic signed [sapq_pkg::KEY_W-1:0] next_key;

        if (j == 0)
        begin : g_first
            // nothing above the top cell: a new key that is not below it lands here
            assign prev_key = ctl.key;
            assign prev_gt  = 1'b1;
        end
        else
        begin : g_mid
            assign prev_key = cell_key[j-1];
            assign prev_gt  = cell_gt[j-1];
        end

        if (j == DEPTH - 1)
        begin : g_last
            assign next_key = cell_key[j];
        end
        else
        begin : g_inner
            assign next_key = cell_key[j+1];
        end

        sapq_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .occupied (count_reg > CNT_W'(j)),
            .prev_key (prev_key),
            .prev_gt  (prev_gt),
            .next_key (next_key),
            .gt       (cell_gt[j]),
            .key      (cell_key[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("key count above depth");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.opcode == sapq_pkg::OP_ENQ && !full)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("enqueue did not grow count");

    a_deq_top: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.opcode == sapq_pkg::OP_DEQ && !empty)
        |=> (rsp.key_out == $past(cell_key[0]) && rsp.status == sapq_pkg::ST_OK))
        else $error("dequeue did not return top cell");

    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("request stalled without held response");

endmodule

`default_nettype wire
